>>> rtl/segregated_fit_free_list_engine_defines.svh
// Assertion macros used by the checker file.
`ifndef SEGREGATED_FIT_FREE_LIST_ENGINE_DEFINES_SVH
`define SEGREGATED_FIT_FREE_LIST_ENGINE_DEFINES_SVH

// Check a property outside of reset.
`define SFL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sfl_pkg.sv
package sfl_pkg;

  localparam int BucketBits  = 4;
  localparam int NumGroups   = 16;
  localparam int AlignBits   = 3;
  localparam int HeaderBytes = 16;
  localparam int PoolEntries = 256;
  localparam int AddrW       = 32;
  localparam int SizeW       = 22;
  localparam int CfgW        = 13;
  localparam int CfgReset    = 64;

  localparam int NumBuckets = 1 << BucketBits;
  localparam int NumClasses = NumGroups * NumBuckets;
  localparam int GrpW       = $clog2(NumGroups);
  localparam int ClsW       = GrpW + BucketBits;
  localparam int EntW       = $clog2(PoolEntries);
  localparam int CntW       = EntW + 1;
  localparam int ReqW       = SizeW + 1;
  localparam int AsizeW     = ReqW - AlignBits;
  localparam int LenW       = $clog2(AsizeW + 1);
  localparam int CmpW       = ReqW + 1;

  // Request kinds
  localparam logic KindRelease = 1'b0;
  localparam logic KindRequest = 1'b1;

  // Result status codes
  localparam logic [1:0] StatDone     = 2'd0;
  localparam logic [1:0] StatNoFit    = 2'd1;
  localparam logic [1:0] StatPoolFull = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] block_address;
    logic [SizeW-1:0] byte_count;
  } sfl_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] granted_address;
    logic [SizeW-1:0] granted_bytes;
  } sfl_rsp_t;

  // Bitmap update from the controller
  typedef struct packed {
    logic            set_en;
    logic [ClsW-1:0] set_idx;
    logic            clr_en;
    logic [ClsW-1:0] clr_idx;
  } sfl_bm_op_t;

  // Class of an aligned user size; NumClasses when above the top group.
  function automatic logic [ClsW:0] class_of(input logic [AsizeW-1:0] asize);
    logic [LenW-1:0]   n;
    logic [LenW-1:0]   grp;
    logic [LenW-1:0]   sh;
    logic [AsizeW-1:0] t;
    n = '0;
    for (int i = 0; i < AsizeW; i++) begin
      if (asize[i]) n = LenW'(i + 1);
    end
    grp = (n > LenW'(BucketBits)) ? n - LenW'(BucketBits) : '0;
    sh  = (grp != '0) ? grp - LenW'(1) : '0;
    t   = asize >> sh;
    if (grp >= LenW'(NumGroups)) begin
      class_of = (ClsW+1)'(NumClasses);
    end else begin
      class_of = (ClsW+1)'({grp[GrpW-1:0], t[BucketBits-1:0]});
    end
  endfunction

  // Smallest aligned size of a class.
  function automatic logic [AsizeW-1:0] class_base(input logic [ClsW-1:0] idx);
    logic [GrpW-1:0]       g;
    logic [BucketBits-1:0] b;
    g = idx[ClsW-1:BucketBits];
    b = idx[BucketBits-1:0];
    if (g == '0) begin
      class_base = AsizeW'(b);
    end else begin
      class_base = (AsizeW'(1) << (LenW'(g) + LenW'(BucketBits - 1)))
                 | (AsizeW'(b) << (g - GrpW'(1)));
    end
  endfunction

endpackage

>>> rtl/segregated_fit_free_list_engine.sv
// Channel    Direction  Payload      Handshake
// in         input      sfl_req_t    in_valid_i / in_stall_o
// out        output     sfl_rsp_t    out_valid_o / out_stall_i
// cfg        input      13-bit data  cfg_we_i (min split bytes)
//
// One request at a time. A release runs through the slot and filing states, a
// request through calc, search, head and entry, and the filing states again if
// it splits; the order is set by the chain of dependent reads: list head memory,
// then entry memory, then the list head of the class that takes the split remainder.
// Reset is asynchronous; all state is usable right after it, with no sweep.
// A stalled result stays in the output register while the next request is
// taken; the engine waits at the end of that request until the output frees.
module segregated_fit_free_list_engine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sfl_pkg::sfl_req_t        in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output sfl_pkg::sfl_rsp_t        out_rsp_o,
  input  logic                     cfg_we_i,
  input  logic [sfl_pkg::CfgW-1:0] cfg_wdata_i
);
  import sfl_pkg::*;

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StRelSlot  = 4'd1;
  localparam logic [3:0] StFileRd   = 4'd2;
  localparam logic [3:0] StFileLink = 4'd3;
  localparam logic [3:0] StReqCalc  = 4'd4;
  localparam logic [3:0] StReqSrch  = 4'd5;
  localparam logic [3:0] StReqHead  = 4'd6;
  localparam logic [3:0] StReqEnt   = 4'd7;
  localparam logic [3:0] StDone     = 4'd8;

  logic [3:0]             state_q;
  sfl_req_t               req_q;
  logic [CfgW-1:0]        cfg_q;
  logic [CntW-1:0]        cnt_q;
  logic [EntW-1:0]        slot_q;
  logic [PoolEntries-1:0] stk_wr_q;
  logic [EntW-1:0]        e_q;
  logic [ClsW:0]          idx_q;
  logic [ReqW-1:0]        need_q;
  logic [ClsW-1:0]        found_q;
  logic [SizeW-1:0]       fsize_q;
  sfl_rsp_t               res_q;
  logic                   out_valid_q;
  sfl_rsp_t               out_q;

  logic [EntW-1:0]   stk_rdata, rel_e;
  logic [EntW-1:0]   head_rdata;
  logic [AddrW-1:0]  ent_addr;
  logic [SizeW-1:0]  ent_size;
  logic [EntW-1:0]   ent_link;
  logic [ReqW-1:0]   need_sum, need;
  logic [AsizeW-1:0] asize, low_mask;
  logic [ClsW:0]     cls_raw, cls_req;
  logic [GrpW-1:0]   g_raw;
  logic              round_up;
  logic [AsizeW-1:0] fasize;
  logic [ClsW:0]     fcls;
  logic [ClsW-1:0]   fidx;
  logic [CmpW-1:0]   ceiling;
  logic              split;
  logic [SizeW-1:0]  rem;
  logic [AddrW-1:0]  new_addr;
  logic              pop_last;
  logic              bm_hit;
  logic [ClsW-1:0]   found;
  logic              found_ok;
  sfl_bm_op_t        bm_op;

  logic            head_we;
  logic [ClsW-1:0] head_waddr, head_raddr;
  logic [EntW-1:0] head_wdata;
  logic            ent_we, link_we, stk_we;
  logic [EntW-1:0] ent_waddr;
  logic [AddrW-1:0] ent_waddr_data;
  logic [SizeW-1:0] ent_wsize;
  logic [EntW-1:0] link_wdata;
  logic            out_free;

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Spare entry: never-written slots hold their reset order
  assign rel_e = stk_wr_q[slot_q] ? stk_rdata : EntW'(PoolEntries - 1) - slot_q;

  // Request size, its class and the round-up to a sure fit
  always_comb begin
    need_sum = ReqW'(req_q.byte_count) + ReqW'(HeaderBytes + (1 << AlignBits) - 1);
    need     = need_sum & ~ReqW'((1 << AlignBits) - 1);
    asize    = AsizeW'((need - ReqW'(HeaderBytes)) >> AlignBits);
    cls_raw  = class_of(asize);
    g_raw    = cls_raw[ClsW-1:BucketBits];
    low_mask = (AsizeW'(1) << (g_raw - GrpW'(1))) - AsizeW'(1);
    round_up = !cls_raw[ClsW] && (g_raw >= GrpW'(2)) && ((asize & low_mask) != '0);
    cls_req  = cls_raw + (ClsW+1)'(round_up);
  end

  // Class of the block being filed, clamped to the last class
  always_comb begin
    fasize = (fsize_q >= SizeW'(HeaderBytes))
           ? AsizeW'((fsize_q - SizeW'(HeaderBytes)) >> AlignBits) : '0;
    fcls   = class_of(fasize);
    fidx   = fcls[ClsW] ? ClsW'(NumClasses - 1) : fcls[ClsW-1:0];
  end

  // Split decision on the popped block
  always_comb begin
    ceiling  = (CmpW'(class_base(idx_q[ClsW-1:0])) << AlignBits) + CmpW'(HeaderBytes);
    split    = (CmpW'(ent_size) >= CmpW'(need_q) + CmpW'(cfg_q)) && (CmpW'(ent_size) > ceiling);
    rem      = ent_size - SizeW'(need_q);
    new_addr = ent_addr + AddrW'(need_q);
    pop_last = ent_link == e_q;
  end

  // Memory ports
  always_comb begin
    head_raddr     = (state_q == StReqSrch) ? found : fidx;
    head_we        = 1'b0;
    head_waddr     = fidx;
    head_wdata     = e_q;
    ent_we         = 1'b0;
    ent_waddr      = e_q;
    ent_waddr_data = new_addr;
    ent_wsize      = rem;
    link_we        = 1'b0;
    link_wdata     = bm_hit ? head_rdata : e_q;
    stk_we         = 1'b0;
    bm_op          = '0;
    bm_op.set_idx  = fidx;
    bm_op.clr_idx  = found_q;
    case (state_q)
      StRelSlot: begin
        ent_we         = 1'b1;
        ent_waddr      = rel_e;
        ent_waddr_data = req_q.block_address;
        ent_wsize      = req_q.byte_count;
      end
      StFileLink: begin
        head_we      = 1'b1;
        link_we      = 1'b1;
        bm_op.set_en = 1'b1;
      end
      StReqEnt: begin
        if (pop_last) begin
          bm_op.clr_en = 1'b1;
        end else begin
          head_we    = 1'b1;
          head_waddr = found_q;
          head_wdata = ent_link;
        end
        ent_we = split;
        stk_we = !split;
      end
      default: begin
      end
    endcase
  end

  sfl_ram #(.Width(EntW), .Depth(NumClasses)) u_heads (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  sfl_ram #(.Width(AddrW), .Depth(PoolEntries)) u_ent_addr (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_waddr_data),
    .raddr_i (head_rdata),
    .rdata_o (ent_addr)
  );

  sfl_ram #(.Width(SizeW), .Depth(PoolEntries)) u_ent_size (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wsize),
    .raddr_i (head_rdata),
    .rdata_o (ent_size)
  );

  sfl_ram #(.Width(EntW), .Depth(PoolEntries)) u_ent_link (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (e_q),
    .wdata_i (link_wdata),
    .raddr_i (head_rdata),
    .rdata_o (ent_link)
  );

  sfl_ram #(.Width(EntW), .Depth(PoolEntries)) u_spare (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (cnt_q[EntW-1:0]),
    .wdata_i (e_q),
    .raddr_i (EntW'(cnt_q - CntW'(1))),
    .rdata_o (stk_rdata)
  );

  sfl_bitmaps u_bitmaps (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (bm_op),
    .query_idx_i (fidx),
    .query_hit_o (bm_hit),
    .start_i     (idx_q[ClsW-1:0]),
    .found_o     (found),
    .found_ok_o  (found_ok)
  );

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        req_q                 <= in_req_i;
        res_q.status          <= (in_req_i.kind == KindRelease && cnt_q == '0)
                                 ? StatPoolFull : StatDone;
        res_q.granted_address <= '0;
        res_q.granted_bytes   <= '0;
      end
      StRelSlot: begin
        e_q     <= rel_e;
        fsize_q <= req_q.byte_count;
      end
      StReqCalc: begin
        need_q <= need;
        idx_q  <= cls_req;
      end
      StReqSrch: begin
        found_q <= found;
        if (idx_q[ClsW] || !found_ok) res_q.status <= StatNoFit;
      end
      StReqHead: e_q <= head_rdata;
      StReqEnt: begin
        res_q.granted_address <= ent_addr;
        res_q.granted_bytes   <= split ? need_q[SizeW-1:0] : ent_size;
        fsize_q               <= rem;
      end
      default: begin
      end
    endcase
    if (state_q == StDone && out_free) out_q <= res_q;
  end

  // Control: sequencer, spare count, config and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= CntW'(PoolEntries);
      slot_q      <= '0;
      stk_wr_q    <= '0;
      cfg_q       <= CfgW'(CfgReset);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (stk_we) stk_wr_q[cnt_q[EntW-1:0]] <= 1'b1;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            if (in_req_i.kind == KindRequest) begin
              state_q <= StReqCalc;
            end else if (cnt_q == '0) begin
              state_q <= StDone;
            end else begin
              cnt_q   <= cnt_q - CntW'(1);
              slot_q  <= EntW'(cnt_q - CntW'(1));
              state_q <= StRelSlot;
            end
          end
        end
        StRelSlot:  state_q <= StFileRd;
        StFileRd:   state_q <= StFileLink;
        StFileLink: state_q <= StDone;
        StReqCalc:  state_q <= StReqSrch;
        StReqSrch:  state_q <= (idx_q[ClsW] || !found_ok) ? StDone : StReqHead;
        StReqHead:  state_q <= StReqEnt;
        StReqEnt: begin
          if (split) begin
            state_q <= StFileRd;
          end else begin
            if (cnt_q < CntW'(PoolEntries)) cnt_q <= cnt_q + CntW'(1);
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      // Raise the result flag on load, drop it once taken
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/sfl_ram.sv
module sfl_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/sfl_bitmaps.sv
module sfl_bitmaps (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfl_pkg::sfl_bm_op_t       op_i,
  input  logic [sfl_pkg::ClsW-1:0]  query_idx_i,
  output logic                      query_hit_o,
  input  logic [sfl_pkg::ClsW-1:0]  start_i,
  output logic [sfl_pkg::ClsW-1:0]  found_o,
  output logic                      found_ok_o
);
  import sfl_pkg::*;

  logic [NumGroups-1:0]                  grp_q, grp_d;
  logic [NumGroups-1:0][NumBuckets-1:0]  bkt_q, bkt_d;
  logic [NumGroups-1:0][NumBuckets-1:0]  mmap;
  logic [NumGroups-1:0]                  hit;
  logic [GrpW-1:0]                       base_g;
  logic [BucketBits-1:0]                 base_b;
  logic [GrpW-1:0]                       sel_g;
  logic [BucketBits-1:0]                 sel_b;
  logic [GrpW-1:0]                       cg;
  logic [BucketBits-1:0]                 cb;
  logic [NumBuckets-1:0]                 cleared;

  // Apply set and clear of one class bit
  always_comb begin
    grp_d   = grp_q;
    bkt_d   = bkt_q;
    cg      = op_i.clr_idx[ClsW-1:BucketBits];
    cb      = op_i.clr_idx[BucketBits-1:0];
    cleared = bkt_q[cg] & ~(NumBuckets'(1) << cb);
    if (op_i.set_en) begin
      bkt_d[op_i.set_idx[ClsW-1:BucketBits]][op_i.set_idx[BucketBits-1:0]] = 1'b1;
      grp_d[op_i.set_idx[ClsW-1:BucketBits]] = 1'b1;
    end
    if (op_i.clr_en) begin
      bkt_d[cg] = cleared;
      if (cleared == '0) grp_d[cg] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
      bkt_q <= '0;
    end else begin
      grp_q <= grp_d;
      bkt_q <= bkt_d;
    end
  end

  assign query_hit_o = bkt_q[query_idx_i[ClsW-1:BucketBits]][query_idx_i[BucketBits-1:0]];

  // Find the first non-empty class at or above the start class
  always_comb begin
    base_g = start_i[ClsW-1:BucketBits];
    base_b = start_i[BucketBits-1:0];
    for (int g = 0; g < NumGroups; g++) begin
      for (int j = 0; j < NumBuckets; j++) begin
        mmap[g][j] = bkt_q[g][j] &&
                     ((GrpW'(g) != base_g) || (BucketBits'(j) >= base_b));
      end
      hit[g] = grp_q[g] && (GrpW'(g) >= base_g) && (mmap[g] != '0);
    end
    sel_g = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (hit[g]) sel_g = GrpW'(g);
    end
    sel_b = '0;
    for (int j = NumBuckets - 1; j >= 0; j--) begin
      if (mmap[sel_g][j]) sel_b = BucketBits'(j);
    end
    found_ok_o = hit != '0;
    found_o    = {sel_g, sel_b};
  end

endmodule

>>> rtl/sfl_checker.sv
module sfl_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input sfl_pkg::sfl_req_t        in_req_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input sfl_pkg::sfl_rsp_t        out_rsp_o,
  input logic                     cfg_we_i,
  input logic [sfl_pkg::CfgW-1:0] cfg_wdata_i
);
  import sfl_pkg::*;
  `include "segregated_fit_free_list_engine_defines.svh"

  // A stalled result holds
  `SFL_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o), "stalled result changed")

  // No result during reset
  `SFL_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")

  // A failed request or release grants nothing
  `SFL_ASSERT(a_fail_zero, clk_i, rst_ni, out_valid_o && out_rsp_o.status != StatDone |-> out_rsp_o.granted_address == '0 && out_rsp_o.granted_bytes == '0, "failure carries a grant")

  // One request at a time: busy right after an accept
  `SFL_ASSERT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "accepted two requests back to back")

endmodule

bind segregated_fit_free_list_engine sfl_checker u_sfl_checker (.*);
